/* src/frd_pkg.sv */
// Shared types and constants of the flow run detector.
package frd_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] OPC_FLOW   = 2'd0;
  localparam logic [1:0] OPC_VOLUME = 2'd1;
  localparam logic [1:0] OPC_TICK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT    = 2'd1;

  localparam logic [31:0] RST_START_THRESHOLD = 32'd128;
  localparam logic [31:0] RST_IDLE_TIMEOUT    = 32'd30;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        sample_ok;
    logic [31:0] value;
    logic [31:0] epoch;
  } in_item_t;

  typedef struct packed {
    logic        run_closed;
    logic        running;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] duration;
    logic [31:0] run_volume;
    logic        volume_valid;
    logic [31:0] mean_flow;
    logic [31:0] peak_flow;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    logic count_nz;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

/* src/frd_ctrl.sv */
// Sequencer of the flow run detector: accept, evaluate, divide, commit.
module frd_ctrl
  import frd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.close && status_i.count_nz) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

/* src/frd_dp.sv */
// Datapath: config registers, run state, serial divider and output register.
module frd_dp
  import frd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o
);

  logic [31:0] thr_q, timeout_q;
  in_item_t    item_q;

  logic        open_q, open_d;
  logic [31:0] begin_q, begin_d;
  logic [31:0] last_q, last_d;
  logic [31:0] peak_q, peak_d;
  logic [63:0] total_q, total_d;
  logic [31:0] count_q, count_d;
  logic [31:0] vas_q, vas_d;
  logic [31:0] vlat_q, vlat_d;
  logic        vseen_q, vseen_d;

  logic [63:0]          dvd_q;
  logic [31:0]          rem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;

  logic        out_valid_q;
  out_item_t   out_q, res;

  // config writes; the user must write only while idle, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= RST_START_THRESHOLD;
      timeout_q <= RST_IDLE_TIMEOUT;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_START_THRESHOLD) thr_q <= cfg_data_i;
      if (cfg_index_i == REG_IDLE_TIMEOUT)    timeout_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_data_i;
  end

  // tick close test, timeout sum formed in 33 bits
  logic        is_tick, closing;
  logic [32:0] deadline;
  assign is_tick  = (item_q.opcode == OPC_TICK);
  assign deadline = {1'b0, last_q} + {1'b0, timeout_q};
  assign closing  = is_tick && open_q && (last_q != '0) &&
                    ({1'b0, item_q.epoch} >= deadline);

  assign status_o.close    = closing;
  assign status_o.count_nz = (count_q != '0);
  assign status_o.div_last = (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // restoring division of flow_total by sample_count, one bit a cycle
  logic [32:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q, dvd_q[63]};
  assign q_bit  = (rem_sh >= {1'b0, count_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q  <= total_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[62:0], q_bit};
      rem_q  <= q_bit ? 32'(rem_sh - {1'b0, count_q}) : rem_sh[31:0];
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // next run state and result for the held transaction
  logic        flow_act;
  logic [64:0] sum_ext;
  logic [63:0] tot_base;
  logic [31:0] cnt_base, peak_base;

  assign flow_act = (item_q.value >= thr_q);

  always_comb begin
    open_d    = open_q;
    begin_d   = begin_q;
    last_d    = last_q;
    peak_d    = peak_q;
    total_d   = total_q;
    count_d   = count_q;
    vas_d     = vas_q;
    vlat_d    = vlat_q;
    vseen_d   = vseen_q;
    tot_base  = total_q;
    cnt_base  = count_q;
    peak_base = peak_q;
    sum_ext   = '0;
    res       = '0;

    if (item_q.opcode == OPC_FLOW && item_q.sample_ok) begin
      if (flow_act) begin
        last_d = item_q.epoch;
        if (!open_q) begin
          open_d    = 1'b1;
          begin_d   = item_q.epoch;
          peak_base = item_q.value;
          tot_base  = '0;
          cnt_base  = '0;
          vas_d     = vseen_q ? vlat_q : '0;
        end
      end
      if (open_d) begin
        sum_ext = {1'b0, tot_base} + {33'd0, item_q.value};
        total_d = sum_ext[64] ? '1 : sum_ext[63:0];
        count_d = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
        peak_d  = (item_q.value > peak_base) ? item_q.value : peak_base;
      end
    end else if (item_q.opcode == OPC_VOLUME && item_q.sample_ok) begin
      vlat_d  = item_q.value;
      vseen_d = 1'b1;
    end else if (closing) begin
      res.run_closed = 1'b1;
      res.start_time = begin_q;
      res.end_time   = last_q;
      res.duration   = (last_q > begin_q) ? last_q - begin_q : '0;
      if (vseen_q) begin
        res.run_volume   = (vlat_q > vas_q) ? vlat_q - vas_q : '0;
        res.volume_valid = 1'b1;
      end
      if (count_q != '0) begin
        res.mean_flow = (dvd_q[63:32] != '0) ? '1 : dvd_q[31:0];
      end
      res.peak_flow = peak_q;
      open_d  = 1'b0;
      begin_d = '0;
      last_d  = '0;
      peak_d  = '0;
      total_d = '0;
      count_d = '0;
    end

    res.running = open_d;
    if (open_d) res.start_time = begin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      begin_q <= '0;
      last_q  <= '0;
      peak_q  <= '0;
      total_q <= '0;
      count_q <= '0;
      vas_q   <= '0;
      vlat_q  <= '0;
      vseen_q <= 1'b0;
    end else if (cmd_i.commit) begin
      open_q  <= open_d;
      begin_q <= begin_d;
      last_q  <= last_d;
      peak_q  <= peak_d;
      total_q <= total_d;
      count_q <= count_d;
      vas_q   <= vas_d;
      vlat_q  <= vlat_d;
      vseen_q <= vseen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/flow_run_detector_top.sv */
// Top level of the flow run detector.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes flow samples,
// cumulative volume samples and time ticks. A transaction is taken when
// valid is high and stall is low. Every input gives one result on the
// output channel (out_valid_o / out_stall_i / out_data_o).
// Config port (cfg_valid_i / cfg_ready_o) is always ready; index 0 is the
// start threshold, index 1 the idle timeout. Write it only while idle.
// An item that does not close a run, or closes one with no flow samples,
// goes from acceptance through evaluation straight to the load of the output
// register. A close with samples first runs the mean through a
// 1-bit-per-cycle 64/32 divider. The next item is accepted the cycle after
// the result is loaded into the output register.
// A stalled receiver holds the output register; a following item is still
// accepted and worked on, and waits only for the register to empty.
// Reset clears run state, volume state and the output valid, and restores
// the threshold to 128 and the timeout to 30 s.
module flow_run_detector_top
  import frd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  frd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  frd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

`ifndef SYNTH
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> status.out_free)
    else $error("result loaded while output register is held");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (status.close && status.count_nz))
    else $error("divider started without a closing run");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !cmd.commit) |=> !out_valid_o)
    else $error("output transaction repeated");

  a_idle_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !(cmd.div_step || cmd.commit))
    else $error("work in progress while accepting input");
`endif

endmodule

/* verif/tb_flow_run_detector_top.sv */
// Self-checking testbench of the flow run detector: directed and random samples, predicted results.
module tb_flow_run_detector_top;
  import frd_pkg::*;

  localparam logic [1:0] OPC_SPARE = 2'd3;   // unassigned opcode, only reports status
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE = 80;       // a little more than the slowest close

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  flow_run_detector_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  in_item_t    sample_q[$];   // items waiting to be offered
  out_item_t   due_results[$];
  int unsigned fail_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          hold_req = 0;

  // predicted block state
  logic [31:0] thr_cfg = RST_START_THRESHOLD;
  logic [31:0] tmo_cfg = RST_IDLE_TIMEOUT;
  logic        run_on = 1'b0;
  logic [31:0] run_start = '0;
  logic [31:0] run_last = '0;
  logic [31:0] run_peak = '0;
  logic [63:0] run_sum = '0;
  logic [31:0] run_cnt = '0;
  logic [31:0] vol_base = '0;
  logic [31:0] vol_now = '0;
  logic        vol_seen = 1'b0;

  // stimulus timeline
  logic [31:0] gen_epoch = '0;
  logic [31:0] hot_epoch = '0;
  logic [31:0] gen_vol = '0;

  function automatic out_item_t predict_run(in_item_t it);
    out_item_t   r;
    logic [64:0] sum;
    logic [63:0] mean;
    r = '0;
    case (it.opcode)
      OPC_FLOW: begin
        if (it.sample_ok) begin
          if (it.value >= thr_cfg) begin
            run_last = it.epoch;
            if (!run_on) begin
              run_on = 1'b1;
              run_start = it.epoch;
              run_peak = it.value;
              run_sum = '0;
              run_cnt = '0;
              vol_base = vol_seen ? vol_now : '0;
            end
          end
          if (run_on) begin
            sum = {1'b0, run_sum} + {33'b0, it.value};
            run_sum = sum[64] ? '1 : sum[63:0];
            if (run_cnt != '1) run_cnt = run_cnt + 1;
            if (it.value > run_peak) run_peak = it.value;
          end
        end
      end
      OPC_VOLUME: begin
        if (it.sample_ok) begin
          vol_now = it.value;
          vol_seen = 1'b1;
        end
      end
      OPC_TICK: begin
        // timeout sum kept at 33 bits so it never wraps
        if (run_on && run_last != '0 &&
            {1'b0, it.epoch} >= {1'b0, run_last} + {1'b0, tmo_cfg}) begin
          r.run_closed = 1'b1;
          r.start_time = run_start;
          r.end_time = run_last;
          r.duration = (run_last > run_start) ? run_last - run_start : '0;
          if (vol_seen) begin
            r.run_volume = (vol_now > vol_base) ? vol_now - vol_base : '0;
            r.volume_valid = 1'b1;
          end
          mean = (run_cnt != '0) ? run_sum / {32'b0, run_cnt} : '0;
          r.mean_flow = (mean[63:32] != '0) ? '1 : mean[31:0];
          r.peak_flow = run_peak;
          run_on = 1'b0;
          run_start = '0;
          run_last = '0;
          run_peak = '0;
          run_sum = '0;
          run_cnt = '0;
        end
      end
      default: ;
    endcase
    r.running = run_on;
    if (run_on) r.start_time = run_start;
    return r;
  endfunction

  task automatic push_item(logic [1:0] opc, logic ok, logic [31:0] val, logic [31:0] ep);
    in_item_t it;
    it.opcode = opc;
    it.sample_ok = ok;
    it.value = val;
    it.epoch = ep;
    sample_q.push_back(it);
  endtask

  task automatic queue_random(int unsigned n);
    int unsigned pick;
    int unsigned span;
    int unsigned d;
    logic [32:0] due;
    logic [31:0] val;
    logic [31:0] ep;
    span = (tmo_cfg < 200) ? tmo_cfg + 4 : 200;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 40 || pick >= 95) begin
        if (pick >= 95) gen_epoch = $urandom();
        else gen_epoch = gen_epoch + $urandom_range(0, span / 4);
        d = $urandom_range(0, 2);
        case ($urandom_range(9))
          0, 1, 2: val = (thr_cfg > 32'hFFFF_FFFF - d) ? '1 : thr_cfg + d;
          3, 4:    val = (thr_cfg < d + 1) ? '0 : thr_cfg - d - 1;
          5, 6, 7: val = $urandom();
          default: val = $urandom_range(0, 255);
        endcase
        if (val >= thr_cfg) hot_epoch = gen_epoch;
        push_item(OPC_FLOW, 1'b1, val, gen_epoch);
      end else if (pick < 52) begin
        case ($urandom_range(9))
          0:       gen_vol = $urandom();
          1:       gen_vol = gen_vol - $urandom_range(0, 300);
          default: gen_vol = gen_vol + $urandom_range(0, 500);
        endcase
        push_item(OPC_VOLUME, 1'b1, gen_vol, gen_epoch);
      end else if (pick < 82) begin
        due = {1'b0, hot_epoch} + {1'b0, tmo_cfg};
        case ($urandom_range(9))
          0, 1, 2: ep = due[32] ? gen_epoch : due[31:0];
          3, 4:    ep = due[32] ? gen_epoch : due[31:0] - 1;
          default: ep = gen_epoch + $urandom_range(0, span);
        endcase
        if (ep > gen_epoch) gen_epoch = ep;
        push_item(OPC_TICK, 1'($urandom_range(1)), $urandom(), ep);
      end else if (pick < 90) begin
        push_item($urandom_range(1) ? OPC_VOLUME : OPC_FLOW, 1'b0, $urandom(), $urandom());
      end else begin
        push_item(OPC_SPARE, 1'($urandom_range(1)), $urandom(), $urandom());
      end
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid <= 1'b0;
    if (idx == REG_START_THRESHOLD) thr_cfg = data;
    else if (idx == REG_IDLE_TIMEOUT) tmo_cfg = data;
  endtask

  task automatic drain_results();
    while (sample_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // driver: holds a stalled transaction, predicts at acceptance
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic     nxt_valid;
    in_item_t nxt_data;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      if (in_valid && !in_stall_o) begin
        due_results.push_back(predict_run(in_data));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data = sample_q.pop_front();
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  // receiver: random stall plus an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int unsigned hold_left;
    int          hold_ack;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_ack = 0;
    end else begin
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        hold_left = LONG_HOLD;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("result with nothing expected: %h", out_data_o);
      end else begin
        want = due_results.pop_front();
        check_field("run_closed", want.run_closed, out_data_o.run_closed);
        check_field("running", want.running, out_data_o.running);
        check_field("start_time", want.start_time, out_data_o.start_time);
        check_field("end_time", want.end_time, out_data_o.end_time);
        check_field("duration", want.duration, out_data_o.duration);
        check_field("run_volume", want.run_volume, out_data_o.run_volume);
        check_field("volume_valid", want.volume_valid, out_data_o.volume_valid);
        check_field("mean_flow", want.mean_flow, out_data_o.mean_flow);
        check_field("peak_flow", want.peak_flow, out_data_o.peak_flow);
      end
    end
  end

  initial begin : main
    logic [31:0] ph_thr [8];
    logic [31:0] ph_tmo [8];
    int unsigned ph_idle [8];
    int unsigned ph_stall [8];
    ph_thr = '{32'd0, 32'hFFFF_FFFF, 32'd1000, $urandom(), 32'd128, 32'd500, 32'd1, 32'd2000};
    ph_tmo = '{32'd0, 32'hFFFF_FFFF, 32'd20, $urandom_range(1, 90), 32'd30, 32'd5, 32'd1,
               32'd60};
    ph_idle = '{0, 47, 0, 8, 47, 0, 8, 0};
    ph_stall = '{0, 0, 47, 8, 0, 47, 8, 0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // no run yet, then a run before any volume is seen
    push_item(OPC_TICK, 1'b1, '0, '0);
    push_item(OPC_SPARE, 1'b1, '1, '1);
    push_item(OPC_FLOW, 1'b0, '1, 32'd3);
    push_item(OPC_VOLUME, 1'b0, '1, 32'd4);
    push_item(OPC_FLOW, 1'b1, 32'd127, 32'd5);
    push_item(OPC_FLOW, 1'b1, 32'd128, 32'd10);
    push_item(OPC_FLOW, 1'b1, 32'd0, 32'd12);
    push_item(OPC_FLOW, 1'b1, '1, 32'd15);
    push_item(OPC_TICK, 1'b1, '0, 32'd44);
    push_item(OPC_TICK, 1'b0, '0, 32'd45);
    // run opened at time zero: ticks cannot close it while its last sample is at zero; volume falls during the run
    push_item(OPC_VOLUME, 1'b1, 32'd5000, 32'd50);
    push_item(OPC_FLOW, 1'b1, 32'd300, 32'd0);
    push_item(OPC_TICK, 1'b1, '0, '1);
    push_item(OPC_VOLUME, 1'b1, 32'd4000, 32'd60);
    push_item(OPC_FLOW, 1'b1, 32'd200, 32'd1);
    push_item(OPC_TICK, 1'b1, '0, 32'd31);
    // run near the top of the time range, end wraps below start
    push_item(OPC_FLOW, 1'b1, 32'd129, 32'hFFFF_FFF0);
    push_item(OPC_TICK, 1'b1, '0, '1);
    push_item(OPC_VOLUME, 1'b1, '1, 32'h10);
    push_item(OPC_FLOW, 1'b1, 32'd1000, 32'd20);
    push_item(OPC_TICK, 1'b1, '1, 32'd50);
    push_item(OPC_SPARE, 1'b0, '0, '0);
    push_item(OPC_TICK, 1'b1, '0, 32'd100);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = ph_idle[ph];
      stall_pct = ph_stall[ph];
      cfg_write(REG_START_THRESHOLD, ph_thr[ph]);
      cfg_write(REG_IDLE_TIMEOUT, ph_tmo[ph]);
      @(negedge clk_i);
      if (ph == 4) begin
        // sender stops until everything is back, then resumes
        queue_random(110);
        drain_results();
        queue_random(110);
      end else begin
        queue_random(220);
        if (ph == 2) hold_req = hold_req + 1;
      end
      drain_results();
    end

    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
